// File: rtl/gbp_pkg.sv
// Shared types and constants for the gshare and BTB branch predictor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gbp_pkg;

  localparam int BTB_INDEX_BITS = 10;
  localparam int HISTORY_BITS   = 8;
  localparam int BTB_DEPTH      = 1 << BTB_INDEX_BITS;
  localparam int PHT_DEPTH      = 1 << HISTORY_BITS;
  localparam int CLR_BITS       = (BTB_INDEX_BITS > HISTORY_BITS) ? BTB_INDEX_BITS
                                                                  : HISTORY_BITS;
  localparam int CLR_DEPTH      = 1 << CLR_BITS;

  typedef logic [BTB_INDEX_BITS-1:0] btb_idx_t;
  typedef logic [HISTORY_BITS-1:0]   pht_idx_t;
  typedef logic [1:0]                pht_cnt_t;

  typedef enum logic {
    FN_PREDICT = 1'b0,
    FN_RESOLVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    BK_NONE   = 2'd0,
    BK_UNCOND = 2'd1,
    BK_COND   = 2'd2,
    BK_REG    = 2'd3
  } branch_kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic        valid;
    logic        cond;
    logic [63:0] tag;
    logic [63:0] target;
  } btb_entry_t;

  typedef struct packed {
    logic       en;
    btb_idx_t   addr;
    btb_entry_t data;
  } btb_wr_t;

  typedef struct packed {
    logic     en;
    pht_idx_t addr;
    pht_cnt_t data;
  } pht_wr_t;

endpackage

// File: rtl/gbp_btb_mem.sv
// Branch target buffer storage: one write port and one registered read port.
// Depends on gbp_pkg for the entry and write request types.
`timescale 1ns / 1ps

module gbp_btb_mem (
  input  logic                clk,
  input  gbp_pkg::btb_wr_t    wr,
  input  logic                rd_en,
  input  gbp_pkg::btb_idx_t   rd_addr,
  output gbp_pkg::btb_entry_t rd_data
);

  gbp_pkg::btb_entry_t mem [gbp_pkg::BTB_DEPTH];
  gbp_pkg::btb_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/gbp_pht_mem.sv
// Pattern history table of two-bit counters: one write port, one registered read port.
// Depends on gbp_pkg for the index, counter and write request types.
`timescale 1ns / 1ps

module gbp_pht_mem (
  input  logic              clk,
  input  gbp_pkg::pht_wr_t  wr,
  input  logic              rd_en,
  input  gbp_pkg::pht_idx_t rd_addr,
  output gbp_pkg::pht_cnt_t rd_data
);

  gbp_pkg::pht_cnt_t mem [gbp_pkg::PHT_DEPTH];
  gbp_pkg::pht_cnt_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/gshare_btb_branch_predictor_top.sv
// Gshare direction predictor with a direct-mapped branch target buffer.
// The memories are read on acceptance; in the lookup state, once the output register is free,
// the result is computed, registered and written back. No new word is accepted until then.
// After reset a clearing pass empties both memories before the first word is accepted.
// Depends on gbp_pkg, gbp_btb_mem and gbp_pht_mem.
`timescale 1ns / 1ps

module gshare_btb_branch_predictor_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [63:0]        in_pc,
  input  logic [1:0]         in_branch_kind,
  input  logic signed [27:0] in_target_offset,
  input  logic               in_actual_taken,
  input  logic               in_earlier_prediction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_predicted_taken,
  output logic [63:0]        out_predicted_target,
  output logic               out_squash,
  output logic               out_fallthrough_redirect,
  output logic [63:0]        out_redirect_address
);

  gbp_pkg::state_t               state_r, state_nxt;
  logic [gbp_pkg::CLR_BITS-1:0]  clr_cnt_r, clr_cnt_nxt;
  gbp_pkg::pht_idx_t             ghr_r, ghr_nxt;

  logic                          func_r;
  logic [63:0]                   pc_r;
  logic [1:0]                    kind_r;
  logic signed [27:0]            off_r;
  logic                          act_r;
  logic                          pred_r;
  gbp_pkg::pht_idx_t             pht_idx_r;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_taken_r, out_taken_nxt;
  logic [63:0]                   out_target_r, out_target_nxt;
  logic                          out_squash_r, out_squash_nxt;
  logic                          out_fr_r, out_fr_nxt;
  logic [63:0]                   out_redir_r, out_redir_nxt;

  gbp_pkg::btb_wr_t              btb_wr;
  gbp_pkg::pht_wr_t              pht_wr;
  gbp_pkg::btb_entry_t           entry;
  gbp_pkg::pht_cnt_t             cnt;
  gbp_pkg::btb_idx_t             in_btb_idx;
  gbp_pkg::pht_idx_t             in_pht_idx;

  logic                          accept;
  logic                          fire;
  logic                          hit;
  logic                          is_br;
  logic                          mispredict;
  logic [63:0]                   resolved;
  logic [63:0]                   pc_plus4;
  gbp_pkg::pht_cnt_t             cnt_step;

  assign in_btb_idx = in_pc[gbp_pkg::BTB_INDEX_BITS+1:2];
  assign in_pht_idx = ghr_r ^ in_pc[gbp_pkg::HISTORY_BITS+1:2];
  assign in_ready   = (state_r == gbp_pkg::ST_IDLE);
  assign accept     = in_valid && in_ready;

  gbp_btb_mem u_btb (
    .clk     (clk),
    .wr      (btb_wr),
    .rd_en   (accept),
    .rd_addr (in_btb_idx),
    .rd_data (entry)
  );

  gbp_pht_mem u_pht (
    .clk     (clk),
    .wr      (pht_wr),
    .rd_en   (accept),
    .rd_addr (in_pht_idx),
    .rd_data (cnt)
  );

  assign hit        = entry.valid && (entry.tag == pc_r);
  assign is_br      = (kind_r != gbp_pkg::BK_NONE);
  assign mispredict = is_br && (pred_r != act_r);
  assign resolved   = pc_r + {{36{off_r[27]}}, off_r};
  assign pc_plus4   = pc_r + 64'd4;
  assign cnt_step   = act_r ? ((cnt == 2'd3) ? cnt : cnt + 2'd1)
                            : ((cnt == 2'd0) ? cnt : cnt - 2'd1);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    ghr_nxt        = ghr_r;
    fire           = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_taken_nxt  = out_taken_r;
    out_target_nxt = out_target_r;
    out_squash_nxt = out_squash_r;
    out_fr_nxt     = out_fr_r;
    out_redir_nxt  = out_redir_r;
    btb_wr         = '0;
    pht_wr         = '0;

    unique case (state_r)
      gbp_pkg::ST_CLEAR: begin
        btb_wr.en   = ({1'b0, clr_cnt_r} < (gbp_pkg::CLR_BITS+1)'(gbp_pkg::BTB_DEPTH));
        btb_wr.addr = clr_cnt_r[gbp_pkg::BTB_INDEX_BITS-1:0];
        pht_wr.en   = ({1'b0, clr_cnt_r} < (gbp_pkg::CLR_BITS+1)'(gbp_pkg::PHT_DEPTH));
        pht_wr.addr = clr_cnt_r[gbp_pkg::HISTORY_BITS-1:0];
        clr_cnt_nxt = clr_cnt_r + gbp_pkg::CLR_BITS'(1);
        if (clr_cnt_r == gbp_pkg::CLR_BITS'(gbp_pkg::CLR_DEPTH - 1)) begin
          state_nxt = gbp_pkg::ST_IDLE;
        end
      end
      gbp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = gbp_pkg::ST_LOOKUP;
        end
      end
      gbp_pkg::ST_LOOKUP: begin
        fire = !out_valid_r || out_ready;
        if (fire) begin
          state_nxt      = gbp_pkg::ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_taken_nxt  = 1'b0;
          out_target_nxt = '0;
          out_squash_nxt = 1'b0;
          out_fr_nxt     = 1'b0;
          out_redir_nxt  = '0;
          if (func_r == gbp_pkg::FN_PREDICT) begin
            if (hit && (!entry.cond || cnt[1])) begin
              out_taken_nxt  = 1'b1;
              out_target_nxt = entry.target;
            end
          end else begin
            out_squash_nxt = mispredict ||
                             (is_br && act_r && hit && (entry.target != resolved));
            if (mispredict && !act_r) begin
              out_fr_nxt    = 1'b1;
              out_redir_nxt = pc_plus4;
            end
            btb_wr.addr = pc_r[gbp_pkg::BTB_INDEX_BITS+1:2];
            if (hit) begin
              btb_wr.en          = 1'b1;
              btb_wr.data        = entry;
              btb_wr.data.target = resolved;
            end else if (is_br) begin
              btb_wr.en          = 1'b1;
              btb_wr.data.valid  = 1'b1;
              btb_wr.data.cond   = (kind_r == gbp_pkg::BK_COND);
              btb_wr.data.tag    = pc_r;
              btb_wr.data.target = resolved;
            end
            if (kind_r == gbp_pkg::BK_COND) begin
              pht_wr.en   = 1'b1;
              pht_wr.addr = pht_idx_r;
              pht_wr.data = cnt_step;
              ghr_nxt     = {ghr_r[gbp_pkg::HISTORY_BITS-2:0], act_r};
            end
          end
        end
      end
      default: begin
        state_nxt = gbp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbp_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      ghr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ghr_r       <= ghr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_func;
      pc_r      <= in_pc;
      kind_r    <= in_branch_kind;
      off_r     <= in_target_offset;
      act_r     <= in_actual_taken;
      pred_r    <= in_earlier_prediction;
      pht_idx_r <= in_pht_idx;
    end
    out_taken_r  <= out_taken_nxt;
    out_target_r <= out_target_nxt;
    out_squash_r <= out_squash_nxt;
    out_fr_r     <= out_fr_nxt;
    out_redir_r  <= out_redir_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_predicted_taken      = out_taken_r;
  assign out_predicted_target     = out_target_r;
  assign out_squash               = out_squash_r;
  assign out_fallthrough_redirect = out_fr_r;
  assign out_redirect_address     = out_redir_r;

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == gbp_pkg::ST_LOOKUP))
    else $error("accepted word did not move to lookup");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == gbp_pkg::ST_LOOKUP))
    else $error("result loaded outside lookup");

  a_redirect_squashes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fallthrough_redirect) |-> out_squash)
    else $error("fallthrough redirect without squash");

  a_predict_or_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_predicted_taken && out_squash))
    else $error("result carries both prediction and squash");

endmodule
